### design/dtm_pkg.sv
// Shared types, constants and tables for the duration text to milliseconds unit.
`timescale 1ns / 1ps
`default_nettype none
package dtm_pkg;

	localparam int UNIT_W    = 27;
	localparam int MUL_A_W   = 32;
	localparam int PROD_W    = MUL_A_W + UNIT_W;
	localparam int DIV_W     = PROD_W + 1;
	localparam int DIVISOR_W = 30;
	localparam int DCNT_W    = $clog2(DIV_W);

	localparam logic [UNIT_W-1:0] MS_PER_MS  = UNIT_W'(1);
	localparam logic [UNIT_W-1:0] MS_PER_SEC = UNIT_W'(1000);
	localparam logic [UNIT_W-1:0] MS_PER_MIN = UNIT_W'(60 * 1000);
	localparam logic [UNIT_W-1:0] MS_PER_HR  = UNIT_W'(60 * 60 * 1000);
	localparam logic [UNIT_W-1:0] MS_PER_DAY = UNIT_W'(24 * 60 * 60 * 1000);

	typedef enum logic [2:0] {
		U_NONE = 3'd0,
		U_S    = 3'd1,
		U_M    = 3'd2,
		U_MS   = 3'd3,
		U_H    = 3'd4,
		U_D    = 3'd5,
		U_BAD  = 3'd6
	} unit_t;

	typedef enum logic [1:0] {
		MSEL_LO = 2'd0,
		MSEL_HI = 2'd1,
		MSEL_FR = 2'd2
	} mul_sel_t;

	typedef struct packed {
		logic     parse;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     acc_first;
		logic     acc_high;
		logic     div_init;
		logic     div_step;
		logic     finish;
	} dtm_cmd_t;

	typedef struct packed {
		logic bad;
		logic div_last;
	} dtm_stat_t;

	function automatic logic [UNIT_W-1:0] unit_ms(input unit_t u);
		logic [UNIT_W-1:0] r;
		case (u)
			U_NONE, U_S: r = MS_PER_SEC;
			U_MS:        r = MS_PER_MS;
			U_M:         r = MS_PER_MIN;
			U_H:         r = MS_PER_HR;
			U_D:         r = MS_PER_DAY;
			default:     r = '0;
		endcase
		return r;
	endfunction

	function automatic logic [DIVISOR_W-1:0] pow10(input logic [3:0] n);
		logic [DIVISOR_W-1:0] r;
		case (n)
			4'd0:    r = DIVISOR_W'(1);
			4'd1:    r = DIVISOR_W'(10);
			4'd2:    r = DIVISOR_W'(100);
			4'd3:    r = DIVISOR_W'(1000);
			4'd4:    r = DIVISOR_W'(10000);
			4'd5:    r = DIVISOR_W'(100000);
			4'd6:    r = DIVISOR_W'(1000000);
			4'd7:    r = DIVISOR_W'(10000000);
			4'd8:    r = DIVISOR_W'(100000000);
			default: r = DIVISOR_W'(1000000000);
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

### design/dtm_text_if.sv
// Text byte channel: one character or end marker per transfer.
`timescale 1ns / 1ps
`default_nettype none
interface dtm_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] character;
	logic       end_of_text;

	modport source (output valid, output character, output end_of_text, input ready);
	modport sink   (input valid, input character, input end_of_text, output ready);
endinterface
`default_nettype wire

### design/dtm_result_if.sv
// Result channel: duration in milliseconds and parse status per transfer.
`timescale 1ns / 1ps
`default_nettype none
interface dtm_result_if;
	logic        valid;
	logic        ready;
	logic [63:0] milliseconds;
	logic        status;

	modport source (output valid, output milliseconds, output status, input ready);
	modport sink   (input valid, input milliseconds, input status, output ready);
endinterface
`default_nettype wire

### design/dtm_datapath.sv
// Parse registers, shared multiplier, bit-serial divider and result register.
`timescale 1ns / 1ps
`default_nettype none
module dtm_datapath #(
	parameter int MAX_FRACTION_DIGITS = 6
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire dtm_pkg::dtm_cmd_t cmd,
	output dtm_pkg::dtm_stat_t     stat,
	input  wire logic [7:0]        character,
	output logic [63:0]            milliseconds,
	output logic                   status
);

	localparam int FRAC_W = $clog2(10 ** MAX_FRACTION_DIGITS);
	localparam int CNT_W  = $clog2(MAX_FRACTION_DIGITS + 1);

	typedef enum logic [1:0] {
		PH_WHOLE,
		PH_FRAC,
		PH_SUFFIX,
		PH_DONE
	} phase_t;

	phase_t                 phase_q;
	logic [63:0]            whole_q;
	logic [FRAC_W-1:0]      frac_q;
	logic [CNT_W-1:0]       fcnt_q;
	logic                   any_digit_q;
	logic                   frac_seen_q;
	dtm_pkg::unit_t         unit_q;

	logic [dtm_pkg::PROD_W-1:0]    prod_q;
	logic [63:0]                   acc_q;
	logic [dtm_pkg::DIV_W-1:0]     dvd_q;
	logic [dtm_pkg::DIVISOR_W-1:0] rem_q;
	logic [dtm_pkg::DIVISOR_W-1:0] div_q;
	logic [dtm_pkg::DCNT_W-1:0]    dcnt_q;

	logic                          is_digit;
	logic [3:0]                    digit;
	logic [dtm_pkg::UNIT_W-1:0]    unit_val;
	logic [dtm_pkg::MUL_A_W-1:0]   mul_a;
	logic [dtm_pkg::DIVISOR_W-1:0] divisor;
	logic [dtm_pkg::DIVISOR_W:0]   rem_ext;
	logic                          qbit;
	logic [dtm_pkg::DIVISOR_W:0]   rem_sub;
	logic [63:0]                   part;

	function automatic dtm_pkg::unit_t next_unit(input dtm_pkg::unit_t u, input logic [7:0] c);
		dtm_pkg::unit_t r;
		r = dtm_pkg::U_BAD;
		if (u == dtm_pkg::U_NONE) begin
			case (c)
				8'h73:   r = dtm_pkg::U_S;
				8'h6D:   r = dtm_pkg::U_M;
				8'h68:   r = dtm_pkg::U_H;
				8'h64:   r = dtm_pkg::U_D;
				default: r = dtm_pkg::U_BAD;
			endcase
		end else if (u == dtm_pkg::U_M && c == 8'h73) begin
			r = dtm_pkg::U_MS;
		end
		return r;
	endfunction

	assign is_digit = (character >= 8'h30) && (character <= 8'h39);
	assign digit    = 4'(character - 8'h30);
	assign unit_val = dtm_pkg::unit_ms(unit_q);
	assign divisor  = dtm_pkg::pow10(4'(fcnt_q));

	always_comb begin
		case (cmd.mul_sel)
			dtm_pkg::MSEL_LO: mul_a = whole_q[31:0];
			dtm_pkg::MSEL_HI: mul_a = whole_q[63:32];
			dtm_pkg::MSEL_FR: mul_a = dtm_pkg::MUL_A_W'(frac_q);
			default:          mul_a = '0;
		endcase
	end

	assign rem_ext = {rem_q, dvd_q[dtm_pkg::DIV_W-1]};
	assign rem_sub = rem_ext - {1'b0, div_q};
	assign qbit    = rem_ext >= {1'b0, div_q};

	always_comb begin
		if (!frac_seen_q)
			part = '0;
		else if (dvd_q == '0 && frac_q != '0)
			part = 64'd1;
		else
			part = 64'(dvd_q);
	end

	assign stat.bad      = (unit_q == dtm_pkg::U_BAD) || !any_digit_q;
	assign stat.div_last = (dcnt_q == '0);

	// parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_WHOLE;
			whole_q     <= '0;
			frac_q      <= '0;
			fcnt_q      <= '0;
			any_digit_q <= 1'b0;
			frac_seen_q <= 1'b0;
			unit_q      <= dtm_pkg::U_NONE;
		end else if (cmd.finish) begin
			phase_q     <= PH_WHOLE;
			whole_q     <= '0;
			frac_q      <= '0;
			fcnt_q      <= '0;
			any_digit_q <= 1'b0;
			frac_seen_q <= 1'b0;
			unit_q      <= dtm_pkg::U_NONE;
		end else if (cmd.parse && phase_q != PH_DONE) begin
			if (character == 8'h00) begin
				phase_q <= PH_DONE;
			end else begin
				case (phase_q)
					PH_WHOLE: begin
						if (is_digit) begin
							any_digit_q <= 1'b1;
							whole_q     <= (whole_q << 3) + (whole_q << 1) + 64'(digit);
						end else if (character == 8'h2E) begin
							phase_q <= PH_FRAC;
						end else begin
							phase_q <= PH_SUFFIX;
							unit_q  <= next_unit(unit_q, character);
						end
					end
					PH_FRAC: begin
						if (is_digit) begin
							any_digit_q <= 1'b1;
							frac_seen_q <= 1'b1;
							if (fcnt_q < CNT_W'(MAX_FRACTION_DIGITS)) begin
								frac_q <= FRAC_W'((frac_q << 3) + (frac_q << 1) + FRAC_W'(digit));
								fcnt_q <= fcnt_q + 1'b1;
							end
						end else begin
							phase_q <= PH_SUFFIX;
							unit_q  <= next_unit(unit_q, character);
						end
					end
					default: unit_q <= next_unit(unit_q, character);
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
		end else if (cmd.div_init) begin
			dcnt_q <= dtm_pkg::DCNT_W'(dtm_pkg::DIV_W - 1);
		end else if (cmd.div_step && dcnt_q != '0) begin
			dcnt_q <= dcnt_q - 1'b1;
		end
	end

	// arithmetic payload
	always_ff @(posedge clk) begin
		if (cmd.mul_en)
			prod_q <= dtm_pkg::PROD_W'(mul_a) * dtm_pkg::PROD_W'(unit_val);
		if (cmd.acc_first)
			acc_q <= 64'(prod_q);
		else if (cmd.acc_high)
			acc_q <= acc_q + {prod_q[31:0], 32'd0};
		if (cmd.div_init) begin
			dvd_q <= dtm_pkg::DIV_W'(prod_q) + dtm_pkg::DIV_W'(divisor >> 1);
			rem_q <= '0;
			div_q <= divisor;
		end else if (cmd.div_step) begin
			dvd_q <= {dvd_q[dtm_pkg::DIV_W-2:0], qbit};
			rem_q <= qbit ? rem_sub[dtm_pkg::DIVISOR_W-1:0] : rem_ext[dtm_pkg::DIVISOR_W-1:0];
		end
		if (cmd.finish) begin
			milliseconds <= stat.bad ? 64'd0 : acc_q + part;
			status       <= stat.bad;
		end
	end

endmodule
`default_nettype wire

### design/dtm_controller.sv
// Sequencer for parsing, multiply, divide and result hand-off.
`timescale 1ns / 1ps
`default_nettype none
module dtm_controller (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic              in_end,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output dtm_pkg::dtm_cmd_t      cmd,
	input  wire dtm_pkg::dtm_stat_t stat
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL0,
		S_MUL1,
		S_MUL2,
		S_DIVI,
		S_DIV,
		S_FIN
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   in_xfer;
	logic   out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign in_xfer   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		cmd           = '0;
		cmd.mul_sel   = dtm_pkg::MSEL_LO;
		case (state_q)
			S_IDLE: cmd.parse = in_xfer && !in_end;
			S_MUL0: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = dtm_pkg::MSEL_LO;
			end
			S_MUL1: begin
				cmd.mul_en    = 1'b1;
				cmd.mul_sel   = dtm_pkg::MSEL_HI;
				cmd.acc_first = 1'b1;
			end
			S_MUL2: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_sel  = dtm_pkg::MSEL_FR;
				cmd.acc_high = 1'b1;
			end
			S_DIVI:  cmd.div_init = 1'b1;
			S_DIV:   cmd.div_step = 1'b1;
			S_FIN:   cmd.finish   = out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.finish)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_xfer && in_end)
						state_q <= stat.bad ? S_FIN : S_MUL0;
				end
				S_MUL0:  state_q <= S_MUL1;
				S_MUL1:  state_q <= S_MUL2;
				S_MUL2:  state_q <= S_DIVI;
				S_DIVI:  state_q <= S_DIV;
				S_DIV: begin
					if (stat.div_last)
						state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_finish_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> out_valid_q)
		else $error("result not presented after finish");

	a_bad_skips_math: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && in_xfer && in_end && stat.bad) |=> state_q == S_FIN)
		else $error("malformed text did not go straight to result");

	a_div_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && !stat.div_last) |=> state_q == S_DIV)
		else $error("divider left early");

	a_fin_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && !out_free) |=> (state_q == S_FIN && out_valid_q))
		else $error("pending result overwritten");

endmodule
`default_nettype wire

### design/duration_text_to_milliseconds_unit.sv
// Top level of the duration text to milliseconds unit.
// Text bytes: one transfer per cycle, no result; in_ready stays high while idle.
// End item: malformed text goes straight to the result state; otherwise three 32x27
// multiplier passes and a 60-step bit-serial divider run before the result is registered.
// A finished result waits in the output register while new text bytes are taken.
// arst_n clears the parse state and the result valid flag at once.
`timescale 1ns / 1ps
`default_nettype none
module duration_text_to_milliseconds_unit #(
	parameter int MAX_FRACTION_DIGITS = 6
) (
	input wire logic      clk,
	input wire logic      arst_n,
	dtm_text_if.sink      text,
	dtm_result_if.source  result
);

	dtm_pkg::dtm_cmd_t  cmd;
	dtm_pkg::dtm_stat_t stat;

	dtm_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (text.valid),
		.in_end    (text.end_of_text),
		.in_ready  (text.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	dtm_datapath #(
		.MAX_FRACTION_DIGITS (MAX_FRACTION_DIGITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.character    (text.character),
		.milliseconds (result.milliseconds),
		.status       (result.status)
	);

endmodule
`default_nettype wire

### tb/sv/tb_duration_text_to_milliseconds_unit.sv
// Self-checking testbench for the duration text to milliseconds unit.
`timescale 1ns / 1ps
module tb_duration_text_to_milliseconds_unit;

	localparam int FRAC_KEEP   = 6;
	localparam int ITEM_TARGET = 1250;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE      = 100;
	localparam int LONG_HOLD   = 400;

	typedef struct packed {
		logic [63:0] milliseconds;
		logic        status;
	} duration_t;

	class duration_scoreboard;
		typedef enum logic [1:0] {PH_WHOLE, PH_FRAC, PH_SUFFIX, PH_DONE} text_phase_t;

		text_phase_t     phase;
		logic [63:0]     whole;
		logic [63:0]     frac;
		int unsigned     frac_count;
		bit              any_digit;
		bit              frac_digit;
		dtm_pkg::unit_t  unit;
		duration_t       awaited[$];
		int              errors;

		function new();
			errors = 0;
			clear_text();
		endfunction

		function void clear_text();
			phase      = PH_WHOLE;
			whole      = '0;
			frac       = '0;
			frac_count = 0;
			any_digit  = 1'b0;
			frac_digit = 1'b0;
			unit       = dtm_pkg::U_NONE;
		endfunction

		function void take_suffix(logic [7:0] ch);
			if (unit == dtm_pkg::U_NONE) begin
				if (ch == "s")
					unit = dtm_pkg::U_S;
				else if (ch == "m")
					unit = dtm_pkg::U_M;
				else if (ch == "h")
					unit = dtm_pkg::U_H;
				else if (ch == "d")
					unit = dtm_pkg::U_D;
				else
					unit = dtm_pkg::U_BAD;
			end else if (unit == dtm_pkg::U_M && ch == "s") begin
				unit = dtm_pkg::U_MS;
			end else begin
				unit = dtm_pkg::U_BAD;
			end
		endfunction

		function duration_t finish_text();
			duration_t   r;
			logic [63:0] per_unit;
			logic [63:0] divisor;
			logic [63:0] part;
			bit          bad;
			bad = !any_digit;
			case (unit)
				dtm_pkg::U_NONE, dtm_pkg::U_S: per_unit = 64'd1000;
				dtm_pkg::U_MS:                 per_unit = 64'd1;
				dtm_pkg::U_M:                  per_unit = 64'd60000;
				dtm_pkg::U_H:                  per_unit = 64'd3600000;
				dtm_pkg::U_D:                  per_unit = 64'd86400000;
				default: begin
					per_unit = '0;
					bad      = 1'b1;
				end
			endcase
			r.status       = bad;
			r.milliseconds = '0;
			if (!bad) begin
				r.milliseconds = whole * per_unit;
				if (frac_digit) begin
					divisor = 64'd1;
					for (int i = 0; i < frac_count; i++)
						divisor = divisor * 64'd10;
					part = (frac * per_unit + divisor / 64'd2) / divisor;
					// a nonzero fraction never rounds away entirely
					if (part == 0 && frac != 0)
						part = 64'd1;
					r.milliseconds = r.milliseconds + part;
				end
			end
			return r;
		endfunction

		function void note_input(logic [7:0] ch, logic eot);
			bit digit;
			digit = (ch >= "0") && (ch <= "9");
			if (eot) begin
				awaited.push_back(finish_text());
				clear_text();
				return;
			end
			if (phase == PH_DONE)
				return;
			if (ch == 8'h00) begin
				phase = PH_DONE;
				return;
			end
			case (phase)
				PH_WHOLE: begin
					if (digit) begin
						any_digit = 1'b1;
						whole     = whole * 64'd10 + (64'(ch) - 64'(8'("0")));
					end else if (ch == ".") begin
						phase = PH_FRAC;
					end else begin
						phase = PH_SUFFIX;
						take_suffix(ch);
					end
				end
				PH_FRAC: begin
					if (digit) begin
						any_digit  = 1'b1;
						frac_digit = 1'b1;
						if (frac_count < FRAC_KEEP) begin
							frac       = frac * 64'd10 + (64'(ch) - 64'(8'("0")));
							frac_count = frac_count + 1;
						end
					end else begin
						phase = PH_SUFFIX;
						take_suffix(ch);
					end
				end
				default: take_suffix(ch);
			endcase
		endfunction

		function void check_result(logic [63:0] ms, logic st);
			duration_t want;
			if (awaited.size() == 0) begin
				$display("%0t: unexpected result, milliseconds %0d status %0d", $time, ms, st);
				errors++;
				return;
			end
			want = awaited.pop_front();
			if (ms !== want.milliseconds) begin
				$display("%0t: milliseconds expected %0d got %0d", $time,
					want.milliseconds, ms);
				errors++;
			end
			if (st !== want.status) begin
				$display("%0t: status expected %0d got %0d", $time, want.status, st);
				errors++;
			end
		endfunction

		function int pending();
			return awaited.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	dtm_text_if   text_bus ();
	dtm_result_if result_bus ();

	duration_text_to_milliseconds_unit #(
		.MAX_FRACTION_DIGITS(FRAC_KEEP)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.text  (text_bus),
		.result(result_bus)
	);

	duration_scoreboard sb = new();

	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	int hold_left = 0;
	int items_sent = 0;
	int cycles = 0;

	initial clk = 1'b0;
	always #1 clk = ~clk;

	task automatic send_item(input logic [7:0] ch, input logic eot);
		while ($urandom_range(99) < tx_idle_pct) begin
			text_bus.valid <= 1'b0;
			@(posedge clk);
		end
		text_bus.valid       <= 1'b1;
		text_bus.character   <= ch;
		text_bus.end_of_text <= eot;
		do
			@(posedge clk);
		while (!text_bus.ready);
		sb.note_input(ch, eot);
		items_sent++;
	endtask

	task automatic send_chars(input string s);
		foreach (s[i])
			send_item(s[i], 1'b0);
	endtask

	task automatic send_end();
		send_item(8'($urandom_range(255)), 1'b1);
	endtask

	task automatic send_string(input string s);
		send_chars(s);
		send_end();
	endtask

	task automatic push_digits(ref logic [7:0] q[$], input int n);
		repeat (n)
			q.push_back(8'("0" + $urandom_range(9)));
	endtask

	// mostly well-formed durations, some corrupted, the rest raw noise
	task automatic send_random_text();
		logic [7:0] q[$];
		int         kind;
		int         spot;
		kind = $urandom_range(99);
		if (kind < 85) begin
			if ($urandom_range(9) == 0)
				push_digits(q, $urandom_range(15, 24));
			else
				push_digits(q, $urandom_range(0, 6));
			if ($urandom_range(1)) begin
				q.push_back(".");
				push_digits(q, $urandom_range(0, 9));
			end
			case ($urandom_range(5))
				1: q.push_back("s");
				2: q.push_back("m");
				3: begin
					q.push_back("m");
					q.push_back("s");
				end
				4: q.push_back("h");
				5: q.push_back("d");
				default: ;
			endcase
			if (kind >= 70) begin
				if (q.size() == 0) begin
					q.push_back(8'($urandom_range(255)));
				end else begin
					spot = $urandom_range(q.size() - 1);
					if ($urandom_range(1))
						q[spot] = 8'($urandom_range(1, 255));
					else
						q.insert(spot, 8'($urandom_range(255)));
				end
			end
		end else begin
			repeat ($urandom_range(1, 8))
				q.push_back(8'($urandom_range(255)));
		end
		foreach (q[i])
			send_item(q[i], 1'b0);
		send_end();
	endtask

	task automatic drain();
		text_bus.valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending() != 0);
	endtask

	// result side: random stalls plus one long hold-off
	initial begin
		forever begin
			@(posedge clk);
			if (result_bus.valid && result_bus.ready)
				sb.check_result(result_bus.milliseconds, result_bus.status);
			if (hold_left > 0) begin
				hold_left--;
				result_bus.ready <= 1'b0;
			end else begin
				result_bus.ready <= ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb_duration_text_to_milliseconds_unit NOT OK");
		$finish;
	end

	initial begin
		int target;
		text_bus.valid       = 1'b0;
		text_bus.character   = 8'h00;
		text_bus.end_of_text = 1'b0;
		result_bus.ready     = 1'b0;
		arst_n               = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_string("");
		send_string("5.");
		send_string(".s");
		send_string("1ms2");
		send_string("2h");
		send_string("3d");
		send_string("1.2345678m");
		send_string("0.0004ms");
		// zero byte ends the text early
		send_chars("7");
		send_item(8'h00, 1'b0);
		send_chars("x");
		send_end();
		send_chars("9");
		send_item(8'hff, 1'b0);
		send_end();
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					tx_idle_pct  = 0;
					rx_stall_pct = 0;
					hold_left    = LONG_HOLD;
				end
				1: begin
					tx_idle_pct  = 84;
					rx_stall_pct = 0;
				end
				2: begin
					tx_idle_pct  = 0;
					rx_stall_pct = 84;
				end
				default: begin
					tx_idle_pct  = 26;
					rx_stall_pct = 26;
				end
			endcase
			target = items_sent + ITEM_TARGET / 4;
			while (items_sent < target)
				send_random_text();
			drain();
		end

		repeat (SETTLE) @(posedge clk);
		if (sb.errors == 0)
			$display("tb_duration_text_to_milliseconds_unit OK");
		else
			$display("tb_duration_text_to_milliseconds_unit NOT OK");
		$finish;
	end
endmodule

### sim.f
design/dtm_pkg.sv
design/dtm_text_if.sv
design/dtm_result_if.sv
design/dtm_datapath.sv
design/dtm_controller.sv
design/duration_text_to_milliseconds_unit.sv
tb/sv/tb_duration_text_to_milliseconds_unit.sv
